// ===== rtl/hgc_pkg.sv =====
package hgc_pkg;

    // Number of CORDIC micro-rotations run; the angle table has 31 entries.
    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_RUN    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

    // Field widths
    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int RAD_W  = 23;
    localparam int DIST_W = 23;
    localparam int CFG_W  = 25;
    localparam int IDX_W  = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SITE_LAT = 2'd0;
    localparam logic [IDX_W-1:0] REG_SITE_LON = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd51200;

    // Angle (degrees * 2^17) and trig datapath widths
    localparam int ANG_W  = 26;
    localparam int RED_W  = 28;
    localparam int TRIG_W = 33;
    localparam int VEC_W  = 34;
    localparam int SQ_W   = 63;
    localparam int ROOT_W = 31;
    localparam int SQ_STEPS = 31;

    localparam logic signed [RED_W-1:0] TURN_Q17    = 28'sd47185920;
    localparam logic signed [RED_W-1:0] HALF_Q17    = 28'sd23592960;
    localparam logic signed [RED_W-1:0] QUARTER_Q17 = 28'sd11796480;

    localparam logic signed [53:0] DEG_TO_RAD_Q32 = 54'sd74961321;
    localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [21:0] KM_SCALE = 22'd3261952;
    localparam logic [DIST_W-1:0] DIST_MAX = 23'd5123863;

    // Pipeline latencies
    localparam int ROT_LAT = CORDIC_RUN + 3;
    localparam int LAT     = 2 * CORDIC_RUN + 39;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/hgc_sincos.sv =====
module hgc_sincos (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [hgc_pkg::ANG_W-1:0]    ang,
    output logic signed [hgc_pkg::TRIG_W-1:0]   sin_out,
    output logic signed [hgc_pkg::TRIG_W-1:0]   cos_out
);
    import hgc_pkg::*;

    logic signed [RED_W-1:0]  a_ext;
    logic signed [RED_W-1:0]  wrap;
    logic signed [RED_W-1:0]  fold;
    logic                     neg_next;
    logic signed [ANG_W-1:0]  m_reg;
    logic                     neg0_reg;
    logic signed [53:0]       rad_prod;
    logic signed [TRIG_W-1:0] z0_reg;
    logic                     neg1_reg;
    logic signed [TRIG_W-1:0] x_reg [CORDIC_RUN];
    logic signed [TRIG_W-1:0] y_reg [CORDIC_RUN];
    logic signed [TRIG_W-1:0] z_reg [CORDIC_RUN];
    logic                     neg_reg [CORDIC_RUN];
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    // Bring the angle into [-180, 180), then fold into [-90, 90].
    always_comb
    begin
        a_ext = RED_W'(ang);
        if (a_ext >= HALF_Q17)
            wrap = a_ext - TURN_Q17;
        else if (a_ext < -HALF_Q17)
            wrap = a_ext + TURN_Q17;
        else
            wrap = a_ext;
        neg_next = 1'b0;
        fold = wrap;
        if (wrap > QUARTER_Q17)
        begin
            fold = wrap - HALF_Q17;
            neg_next = 1'b1;
        end
        else if (wrap < -QUARTER_Q17)
        begin
            fold = wrap + HALF_Q17;
            neg_next = 1'b1;
        end
    end

    assign rad_prod = 54'(m_reg) * DEG_TO_RAD_Q32;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= fold[ANG_W-1:0];
            neg0_reg <= neg_next;
            z0_reg   <= rad_prod[51:19];
            neg1_reg <= neg0_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_RUN; i++)
        begin : g_rot
            logic signed [TRIG_W-1:0] xi, yi, zi;
            logic                     ni;
            logic signed [TRIG_W-1:0] at;
            if (i == 0)
            begin : g_first
                assign xi = INV_GAIN_Q30;
                assign yi = '0;
                assign zi = z0_reg;
                assign ni = neg1_reg;
            end
            else
            begin : g_next
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign ni = neg_reg[i-1];
            end
            assign at = TRIG_W'(atan_q30(i));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (zi >= 0)
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                        z_reg[i] <= zi - at;
                    end
                    else
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                        z_reg[i] <= zi + at;
                    end
                    neg_reg[i] <= ni;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= neg_reg[CORDIC_RUN-1] ? -y_reg[CORDIC_RUN-1] : y_reg[CORDIC_RUN-1];
            cos_reg <= neg_reg[CORDIC_RUN-1] ? -x_reg[CORDIC_RUN-1] : x_reg[CORDIC_RUN-1];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ===== rtl/hgc_isqrt.sv =====
module hgc_isqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [30:0]                   val,
    output logic [hgc_pkg::ROOT_W-1:0]    root
);
    import hgc_pkg::*;

    logic [SQ_W-1:0] n_reg   [SQ_STEPS];
    logic [SQ_W-1:0] res_reg [SQ_STEPS];

    // One root bit per stage on the radicand val * 2^30.
    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_step
            logic [SQ_W-1:0] ni, ri, trial;
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
            if (k == 0)
            begin : g_first
                assign ni = {2'b00, val, 30'b0};
                assign ri = '0;
            end
            else
            begin : g_next
                assign ni = n_reg[k-1];
                assign ri = res_reg[k-1];
            end
            assign trial = ri + BIT;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (ni >= trial)
                    begin
                        n_reg[k]   <= ni - trial;
                        res_reg[k] <= (ri >> 1) + BIT;
                    end
                    else
                    begin
                        n_reg[k]   <= ni;
                        res_reg[k] <= ri >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = res_reg[SQ_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/hgc_vecang.sv =====
module hgc_vecang (
    input  logic                               clk,
    input  logic                               en,
    input  logic [hgc_pkg::ROOT_W-1:0]         x_in,
    input  logic [hgc_pkg::ROOT_W-1:0]         y_in,
    output logic signed [hgc_pkg::TRIG_W-1:0]  angle
);
    import hgc_pkg::*;

    logic signed [VEC_W-1:0]  x_reg [CORDIC_RUN];
    logic signed [VEC_W-1:0]  y_reg [CORDIC_RUN];
    logic signed [TRIG_W-1:0] z_reg [CORDIC_RUN];

    genvar i;
    generate
        for (i = 0; i < CORDIC_RUN; i++)
        begin : g_vec
            logic signed [VEC_W-1:0]  xi, yi;
            logic signed [TRIG_W-1:0] zi;
            logic signed [TRIG_W-1:0] at;
            if (i == 0)
            begin : g_first
                assign xi = VEC_W'(x_in);
                assign yi = VEC_W'(y_in);
                assign zi = '0;
            end
            else
            begin : g_next
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
            end
            assign at = TRIG_W'(atan_q30(i));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (yi > 0)
                    begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                        z_reg[i] <= zi + at;
                    end
                    else
                    begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                        z_reg[i] <= zi - at;
                    end
                end
            end
        end
    endgenerate

    assign angle = z_reg[CORDIC_RUN-1];

endmodule

// ===== rtl/haversine_geofence_check.sv =====
// Haversine geofence check. Each request carries one position report
// (latitude and longitude in degrees * 65536, plus an on-ground flag) and
// yields one result: the great-circle distance to the configured site on a
// 6371 km sphere in units of 1/256 km, rounded and saturated at half the
// circumference, and a nearby flag set when the craft is airborne and the
// distance does not exceed the watch radius. The datapath is a fully
// pipelined chain: angle reduction and scaling, four parallel rotation
// CORDICs, three register stages forming the haversine term, two 31-stage
// square-root pipelines, a vectoring CORDIC and a final scale and round.
// One request enters every cycle unless the pipe holds. The whole pipe
// advances together and holds when the output register is full and
// out_ready is low. Configure the site and the radius through the write
// port only while no request is in flight.
module haversine_geofence_check (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [hgc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [hgc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [hgc_pkg::LAT_W-1:0]   craft_latitude,
    input  logic signed [hgc_pkg::LON_W-1:0]   craft_longitude,
    input  logic                               on_ground,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [hgc_pkg::DIST_W-1:0]         distance,
    output logic                               nearby
);
    import hgc_pkg::*;

    logic signed [LAT_W-1:0] site_lat_reg;
    logic signed [LON_W-1:0] site_lon_reg;
    logic [RAD_W-1:0]        radius_reg;

    logic en;
    logic vld_reg [LAT];
    logic gnd_reg [LAT];

    logic signed [ANG_W-1:0] ang_dlat, ang_dlon, ang_site, ang_craft;
    logic signed [TRIG_W-1:0] s_lat, s_lon, c_site, c_craft;
    logic signed [TRIG_W-1:0] unused_c0, unused_c1, unused_s0, unused_s1;

    logic signed [65:0] sq_lat, sq_lon, sq_cos;
    logic signed [67:0] sq_mix;
    logic signed [33:0] h_lat_reg, h_lon_reg, prod_reg;
    logic signed [33:0] h_lat2_reg, mix_reg;
    logic signed [34:0] a_sum;
    logic [30:0]        a_reg, na_reg;
    logic [ROOT_W-1:0]  root_a, root_na;
    logic signed [TRIG_W-1:0] half_angle;
    logic [31:0]        z_clamped;
    logic [53:0]        km_reg;
    logic [24:0]        dist_round;
    logic [DIST_W-1:0]  dist_sat;
    logic [DIST_W-1:0]  dist_reg;
    logic               nearby_reg;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_lat_reg <= '0;
            site_lon_reg <= '0;
            radius_reg   <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SITE_LAT: site_lat_reg <= cfg_data[LAT_W-1:0];
                REG_SITE_LON: site_lon_reg <= cfg_data[LON_W-1:0];
                REG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                default:      ;
            endcase
        end
    end

    // Advance the pipe unless a finished result is still waiting.
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gnd_reg[0] <= on_ground;
            for (int k = 1; k < LAT; k++)
                gnd_reg[k] <= gnd_reg[k-1];
        end
    end

    // Half differences are exact: a Q16 difference read as Q17 degrees.
    assign ang_dlat  = ANG_W'(craft_latitude) - ANG_W'(site_lat_reg);
    assign ang_dlon  = ANG_W'(craft_longitude) - ANG_W'(site_lon_reg);
    assign ang_site  = {site_lat_reg[LAT_W-1], site_lat_reg, 1'b0};
    assign ang_craft = {craft_latitude[LAT_W-1], craft_latitude, 1'b0};

    hgc_sincos u_dlat  (.clk, .en, .ang(ang_dlat),  .sin_out(s_lat),     .cos_out(unused_c0));
    hgc_sincos u_dlon  (.clk, .en, .ang(ang_dlon),  .sin_out(s_lon),     .cos_out(unused_c1));
    hgc_sincos u_site  (.clk, .en, .ang(ang_site),  .sin_out(unused_s0), .cos_out(c_site));
    hgc_sincos u_craft (.clk, .en, .ang(ang_craft), .sin_out(unused_s1), .cos_out(c_craft));

    // Haversine term: squares, cosine product, then the cross product.
    assign sq_lat = 66'(s_lat) * 66'(s_lat);
    assign sq_lon = 66'(s_lon) * 66'(s_lon);
    assign sq_cos = 66'(c_site) * 66'(c_craft);
    assign sq_mix = 68'(prod_reg) * 68'(h_lon_reg);
    assign a_sum  = 35'(h_lat2_reg) + 35'(mix_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_lat_reg  <= sq_lat[63:30];
            h_lon_reg  <= sq_lon[63:30];
            prod_reg   <= sq_cos[63:30];
            h_lat2_reg <= h_lat_reg;
            mix_reg    <= sq_mix[63:30];
            // Clamp a to [0, 1].
            if (a_sum < 0)
            begin
                a_reg  <= '0;
                na_reg <= ONE_Q30;
            end
            else if (a_sum > 35'(ONE_Q30))
            begin
                a_reg  <= ONE_Q30;
                na_reg <= '0;
            end
            else
            begin
                a_reg  <= a_sum[30:0];
                na_reg <= ONE_Q30 - a_sum[30:0];
            end
        end
    end

    hgc_isqrt u_sqrt_a  (.clk, .en, .val(a_reg),  .root(root_a));
    hgc_isqrt u_sqrt_na (.clk, .en, .val(na_reg), .root(root_na));

    hgc_vecang u_atan (.clk, .en, .x_in(root_na), .y_in(root_a), .angle(half_angle));

    // Scale the half angle to 1/256 km, round, saturate.
    assign z_clamped  = half_angle[TRIG_W-1] ? '0 : half_angle[31:0];
    assign dist_round = 25'((km_reg + 54'h2000_0000) >> 30);
    assign dist_sat   = (dist_round > 25'(DIST_MAX)) ? DIST_MAX : dist_round[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            km_reg     <= 54'(z_clamped) * 54'(KM_SCALE);
            dist_reg   <= dist_sat;
            nearby_reg <= !gnd_reg[LAT-2] && (dist_sat <= radius_reg);
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign distance  = dist_reg;
    assign nearby    = nearby_reg;

endmodule
